/* sv/sqwt_pkg.sv */
// Package: item types, lexer states, character and event codes, and result builder for the tokenizer.
`default_nettype none

package sqwt_pkg;

   localparam int MAX_WORDS = 255;
   localparam logic [7:0] WORD_CAP = 8'((MAX_WORDS < 255) ? MAX_WORDS : 255);

   // lexer states
   localparam logic [2:0] ST_OUT      = 3'd0;
   localparam logic [2:0] ST_OUT_BSL  = 3'd1;
   localparam logic [2:0] ST_WORD     = 3'd2;
   localparam logic [2:0] ST_WORD_BSL = 3'd3;
   localparam logic [2:0] ST_SQUOTE   = 3'd4;
   localparam logic [2:0] ST_DQUOTE   = 3'd5;
   localparam logic [2:0] ST_DQ_BSL   = 3'd6;

   // event kinds
   localparam logic [2:0] EV_START = 3'd0;
   localparam logic [2:0] EV_CHAR  = 3'd1;
   localparam logic [2:0] EV_END   = 3'd2;
   localparam logic [2:0] EV_CMD   = 3'd3;
   localparam logic [2:0] EV_EOF   = 3'd4;

   // characters
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_VT     = 8'h0B;
   localparam logic [7:0] CH_FF     = 8'h0C;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DQ     = 8'h22;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_AMP    = 8'h26;
   localparam logic [7:0] CH_SQ     = 8'h27;
   localparam logic [7:0] CH_LPAR   = 8'h28;
   localparam logic [7:0] CH_RPAR   = 8'h29;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_BSL    = 8'h5C;
   localparam logic [7:0] CH_BTICK  = 8'h60;
   localparam logic [7:0] CH_PIPE   = 8'h7C;

   localparam int RES_DEPTH = 3;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_input;
   } req_item_type;

   typedef struct packed {
      logic [2:0] event_kind;
      logic [7:0] out_char;
      logic       eof_warning;
      logic [7:0] words_in_command;
      logic       last_of_run;
   } rsp_item_type;

   // everything one item produces, from lexer to the result buffer
   typedef struct packed {
      rsp_item_type [RES_DEPTH-1:0] res;
      logic [1:0]                   count;
      logic [2:0]                   next_state;
      logic [7:0]                   next_wc;
   } step_type;

   function automatic rsp_item_type mk_rsp(input logic [2:0] kind, input logic [7:0] ch,
                                           input logic [7:0] words);
      rsp_item_type r;
      r.event_kind       = kind;
      r.out_char         = ch;
      r.eof_warning      = 1'b0;
      r.words_in_command = words;
      r.last_of_run      = 1'b0;
      return r;
   endfunction

endpackage

`default_nettype wire

/* sv/sqwt_lexer.sv */
// Lexer step: results, next state and next word count for one item.
`default_nettype none

module sqwt_lexer
   import sqwt_pkg::*;
(
   input  req_item_type item,
   input  logic [2:0]   state,
   input  logic [7:0]   wc,
   output step_type     step
);

   logic [7:0] c;
   logic [7:0] wc_inc;
   logic       is_nl;
   logic       is_blank;
   logic       is_meta;

   assign c        = item.char_code;
   assign wc_inc   = (wc < WORD_CAP) ? wc + 8'd1 : wc;
   assign is_nl    = (c == CH_NL);
   assign is_blank = (c == CH_SPACE) || (c == CH_FF) || (c == CH_CR) ||
                     (c == CH_TAB) || (c == CH_VT);
   assign is_meta  = (c == CH_AMP) || (c == CH_LPAR) || (c == CH_RPAR) ||
                     (c == CH_SEMI) || (c == CH_LT) || (c == CH_GT) ||
                     (c == CH_BTICK) || (c == CH_PIPE) || (c == CH_DOLLAR);

   always_comb begin
      logic warn;
      step            = '0;
      step.next_state = state;
      step.next_wc    = wc;
      warn            = 1'b0;
      if (item.end_of_input) begin
         warn = (state == ST_OUT_BSL) || (state == ST_WORD_BSL) || (state == ST_SQUOTE) ||
                (state == ST_DQUOTE) || (state == ST_DQ_BSL);
         if ((state == ST_WORD) || (state == ST_WORD_BSL) || (state == ST_SQUOTE) ||
             (state == ST_DQUOTE) || (state == ST_DQ_BSL)) begin
            step.res[0] = mk_rsp(EV_END, 8'd0, wc);
            step.res[1] = mk_rsp(EV_EOF, 8'd0, wc);
            step.count  = 2'd2;
         end else begin
            step.res[0] = mk_rsp(EV_EOF, 8'd0, wc);
            step.count  = 2'd1;
         end
         step.next_state = ST_OUT;
         step.next_wc    = 8'd0;
      end else begin
         case (state)
            ST_OUT_BSL: begin
               if (is_nl) begin
                  step.next_state = ST_OUT;
               end else begin
                  step.res[0]     = mk_rsp(EV_START, 8'd0, wc_inc);
                  step.res[1]     = mk_rsp(EV_CHAR, c, wc_inc);
                  step.count      = 2'd2;
                  step.next_state = ST_WORD;
                  step.next_wc    = wc_inc;
               end
            end
            ST_WORD: begin
               if (is_blank) begin
                  step.res[0]     = mk_rsp(EV_END, 8'd0, wc);
                  step.count      = 2'd1;
                  step.next_state = ST_OUT;
               end else if (is_nl) begin
                  step.res[0]     = mk_rsp(EV_END, 8'd0, wc);
                  step.res[1]     = mk_rsp(EV_CMD, 8'd0, wc);
                  step.count      = 2'd2;
                  step.next_state = ST_OUT;
                  step.next_wc    = 8'd0;
               end else if (is_meta) begin
                  // end the word, then the metacharacter opens a new word
                  step.res[0]     = mk_rsp(EV_END, 8'd0, wc);
                  step.res[1]     = mk_rsp(EV_START, 8'd0, wc_inc);
                  step.res[2]     = mk_rsp(EV_CHAR, c, wc_inc);
                  step.count      = 2'd3;
                  step.next_wc    = wc_inc;
               end else if (c == CH_BSL) begin
                  step.next_state = ST_WORD_BSL;
               end else if (c == CH_SQ) begin
                  step.next_state = ST_SQUOTE;
               end else if (c == CH_DQ) begin
                  step.next_state = ST_DQUOTE;
               end else begin
                  step.res[0] = mk_rsp(EV_CHAR, c, wc);
                  step.count  = 2'd1;
               end
            end
            ST_WORD_BSL: begin
               if (!is_nl) begin
                  step.res[0] = mk_rsp(EV_CHAR, c, wc);
                  step.count  = 2'd1;
               end
               step.next_state = ST_WORD;
            end
            ST_SQUOTE: begin
               if (c == CH_SQ) begin
                  step.next_state = ST_WORD;
               end else begin
                  step.res[0] = mk_rsp(EV_CHAR, c, wc);
                  step.count  = 2'd1;
               end
            end
            ST_DQUOTE: begin
               if (c == CH_DQ) begin
                  step.next_state = ST_WORD;
               end else if (c == CH_BSL) begin
                  step.next_state = ST_DQ_BSL;
               end else begin
                  step.res[0] = mk_rsp(EV_CHAR, c, wc);
                  step.count  = 2'd1;
               end
            end
            ST_DQ_BSL: begin
               if ((c == CH_DOLLAR) || (c == CH_BTICK) || (c == CH_DQ) || (c == CH_BSL)) begin
                  step.res[0] = mk_rsp(EV_CHAR, c, wc);
                  step.count  = 2'd1;
               end else if (!is_nl) begin
                  // keep the backslash itself
                  step.res[0] = mk_rsp(EV_CHAR, CH_BSL, wc);
                  step.res[1] = mk_rsp(EV_CHAR, c, wc);
                  step.count  = 2'd2;
               end
               step.next_state = ST_DQUOTE;
            end
            default: begin
               if (is_nl) begin
                  step.res[0]     = mk_rsp(EV_CMD, 8'd0, wc);
                  step.count      = 2'd1;
                  step.next_state = ST_OUT;
                  step.next_wc    = 8'd0;
               end else if (is_blank) begin
                  step.next_state = ST_OUT;
               end else if (c == CH_BSL) begin
                  step.next_state = ST_OUT_BSL;
               end else if (c == CH_SQ) begin
                  step.res[0]     = mk_rsp(EV_START, 8'd0, wc_inc);
                  step.count      = 2'd1;
                  step.next_state = ST_SQUOTE;
                  step.next_wc    = wc_inc;
               end else if (c == CH_DQ) begin
                  step.res[0]     = mk_rsp(EV_START, 8'd0, wc_inc);
                  step.count      = 2'd1;
                  step.next_state = ST_DQUOTE;
                  step.next_wc    = wc_inc;
               end else begin
                  step.res[0]     = mk_rsp(EV_START, 8'd0, wc_inc);
                  step.res[1]     = mk_rsp(EV_CHAR, c, wc_inc);
                  step.count      = 2'd2;
                  step.next_state = ST_WORD;
                  step.next_wc    = wc_inc;
               end
            end
         endcase
      end
      for (int i = 0; i < RES_DEPTH; i++) begin
         step.res[i].eof_warning = warn;
         step.res[i].last_of_run = (step.count == 2'(i + 1));
      end
   end

endmodule

`default_nettype wire

/* sv/shell_quote_word_tokenizer_core.sv */
// Top level: input register, lexer step, and result buffer of the shell word tokenizer.
//
//   channel  | ports                          | moves
//   ---------+--------------------------------+--------------------------------
//   request  | req_valid req_ready req_item   | one character or end mark
//   response | rsp_valid rsp_ready rsp_item   | one token event
//
// An accepted item waits in the input register until the result buffer is free; then the
// lexer step loads its zero to three results into the result buffer, and results leave
// one per cycle while rsp_ready is high. While one item's results drain through the single
// response port, the input register takes the next item.
// Reset clears lexer state, word count, and the occupancy of the input register and result buffer.
// Either side may stall at any time; nothing is dropped or repeated.
`default_nettype none

module shell_quote_word_tokenizer_core
   import sqwt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_item
);

   logic                         in_vld_ff, in_vld_in;
   req_item_type                 in_item_ff;
   logic [2:0]                   state_ff, state_in;
   logic [7:0]                   wc_ff, wc_in;
   rsp_item_type [RES_DEPTH-1:0] buf_ff;
   logic [1:0]                   cnt_ff, cnt_in;
   logic [1:0]                   idx_ff, idx_in;

   step_type step;
   logic     take;
   logic     last_take;
   logic     buf_free;
   logic     load;

   sqwt_lexer u_lexer (
      .item  (in_item_ff),
      .state (state_ff),
      .wc    (wc_ff),
      .step  (step)
   );

   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_item  = buf_ff[idx_ff];
   assign take      = rsp_valid && rsp_ready;
   assign last_take = take && ((idx_ff + 2'd1) == cnt_ff);
   assign buf_free  = !rsp_valid || last_take;
   assign load      = in_vld_ff && buf_free;
   assign req_ready = !in_vld_ff || load;

   always_comb begin
      in_vld_in = in_vld_ff;
      state_in  = state_ff;
      wc_in     = wc_ff;
      cnt_in    = cnt_ff;
      idx_in    = idx_ff;
      if (req_valid && req_ready) begin
         in_vld_in = 1'b1;
      end else if (load) begin
         in_vld_in = 1'b0;
      end
      if (load) begin
         state_in = step.next_state;
         wc_in    = step.next_wc;
         cnt_in   = step.count;
         idx_in   = 2'd0;
      end else if (last_take) begin
         cnt_in = 2'd0;
         idx_in = 2'd0;
      end else if (take) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         state_ff  <= ST_OUT;
         wc_ff     <= 8'd0;
         cnt_ff    <= 2'd0;
         idx_ff    <= 2'd0;
      end else begin
         in_vld_ff <= in_vld_in;
         state_ff  <= state_in;
         wc_ff     <= wc_in;
         cnt_ff    <= cnt_in;
         idx_ff    <= idx_in;
      end
   end

   // payload: no reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_item;
      end
      if (load) begin
         buf_ff <= step.res;
      end
   end

endmodule

`default_nettype wire

/* sv/sqwt_checker.sv */
// Checker on the tokenizer ports, bound to the top level.
`default_nettype none

module sqwt_checker
   import sqwt_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_valid,
   input wire logic         req_ready,
   input wire logic         rsp_valid,
   input wire logic         rsp_ready,
   input wire rsp_item_type rsp_item
);

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // input backs up only while a result waits
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("request stalled with no result pending");

   // rest of a run is already buffered
   a_run_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_item.last_of_run) |=> rsp_valid)
      else $error("gap inside a run of results");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_item)))
      else $error("stalled result changed or dropped");

endmodule

bind shell_quote_word_tokenizer_core sqwt_checker u_sqwt_checker (.*);

`default_nettype wire
